### rtl/core/bloom_filter_insert_query_top_defines.svh
// Assertion macros for the bloom filter block.
`ifndef BLOOM_FILTER_INSERT_QUERY_TOP_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_TOP_DEFINES_SVH
// Implication checked on every rising clock edge, disabled while in reset.
`define BF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define BF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/core/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared constants and types of the bloom filter block.
// ----------------------------------------------------------------------------
package bfiq_pkg;
	localparam int unsigned STORE_BITS_DEF = 65536;
	localparam int unsigned MAX_HASHES_DEF = 2;
	localparam int unsigned KEY_W = 63;
	localparam int unsigned CNT_W = 17;
	localparam int unsigned CFG_AW = 5;

	localparam logic [CFG_AW-1:0] REG_HASH_COUNT = 5'd0;
	localparam logic [CFG_AW-1:0] REG_BIT_COUNT = 5'd4;
	localparam logic [CFG_AW-1:0] REG_MULT_FIRST = 5'd8;
	localparam logic [CFG_AW-1:0] REG_OFFSET_FIRST = 5'd12;
	localparam logic [CFG_AW-1:0] REG_PRIME_FIRST = 5'd16;
	localparam logic [CFG_AW-1:0] REG_MULT_SECOND = 5'd20;
	localparam logic [CFG_AW-1:0] REG_OFFSET_SECOND = 5'd24;
	localparam logic [CFG_AW-1:0] REG_PRIME_SECOND = 5'd28;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic [1:0] hash_count;
		logic [16:0] bit_count;
		logic [31:0] mult_first;
		logic [31:0] offset_first;
		logic [31:0] prime_first;
		logic [31:0] mult_second;
		logic [31:0] offset_second;
		logic [31:0] prime_second;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // latch item, start hash 0
		logic start_hash; // start hash of sel
		logic sel;        // which hash
		logic div_start;  // start a divide on current operands
		logic step_mul;   // go to next phase
		logic mem_rd;
		logic mem_wr;
		logic take;       // fold read bit into result
		logic clear_wr;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_busy;
		logic [1:0] phase; // 0 key%p, 1 a*r%p, 2 (r+b)%p, 3 h%n
		logic zero_p;
	} dp_sts_t;

	localparam logic [1:0] PH_KEY = 2'd0;
	localparam logic [1:0] PH_MUL = 2'd1;
	localparam logic [1:0] PH_ADD = 2'd2;
	localparam logic [1:0] PH_IDX = 2'd3;
endpackage

### rtl/core/bfiq_if.sv
// ----------------------------------------------------------------------------
// bfiq_in_if / bfiq_out_if
// Valid/ready channels of the bloom filter block.
// ----------------------------------------------------------------------------
interface bfiq_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [62:0] key;
	modport source (output valid, command, key, input ready);
	modport sink (input valid, command, key, output ready);
endinterface

interface bfiq_out_if;
	logic valid;
	logic ready;
	logic [1:0] newly_set;
	logic present;
	modport source (output valid, newly_set, present, input ready);
	modport sink (input valid, newly_set, present, output ready);
endinterface

### rtl/core/bfiq_div.sv
// ----------------------------------------------------------------------------
// bfiq_div
// Restoring divider, one quotient bit per cycle; returns 64-by-32 remainder.
// ----------------------------------------------------------------------------
module bfiq_div
	import bfiq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [31:0] divisor,
	output logic busy,
	output logic [31:0] rem
);
	logic [63:0] num_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [6:0] cnt_q;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], num_q[63]};
	assign busy = (cnt_q != 7'd0);
	assign rem = rem_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[62:0], 1'b0};
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= shifted - {1'b0, den_q};
			end else begin
				rem_q <= shifted;
			end
		end
	end
endmodule

### rtl/core/bfiq_datapath.sv
// ----------------------------------------------------------------------------
// bfiq_datapath
// Hash operands, shared divider, multiplier, bit store and result registers.
// ----------------------------------------------------------------------------
module bfiq_datapath
	import bfiq_pkg::*;
#(
	parameter int unsigned STORE_BITS = STORE_BITS_DEF,
	parameter int unsigned MAX_HASHES = MAX_HASHES_DEF
)(
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input dp_cmd_t cmd,
	input logic [$clog2(STORE_BITS)-1:0] clr_addr,
	input logic in_command,
	input logic [KEY_W-1:0] in_key,
	output dp_sts_t sts,
	output logic used_two,
	output logic [1:0] newly_set,
	output logic present
);
	localparam int unsigned AW = $clog2(STORE_BITS);
	localparam int unsigned NW = AW + 1;

	logic mem_q [STORE_BITS];
	logic rd_q;
	logic command_q;
	logic [KEY_W-1:0] key_q;
	logic [31:0] r_q;
	logic [1:0] phase_q;
	logic [AW-1:0] idx_q;
	logic [1:0] fresh_q;
	logic all_q;
	logic [63:0] prod_q;

	logic [31:0] a_sel, b_sel, p_sel, rem;
	logic [NW-1:0] nbits;
	logic [63:0] dvd;
	logic [31:0] dvs;
	logic div_busy;

	assign a_sel = cmd.sel ? cfg.mult_second : cfg.mult_first;
	assign b_sel = cmd.sel ? cfg.offset_second : cfg.offset_first;
	assign p_sel = cmd.sel ? cfg.prime_second : cfg.prime_first;
	assign used_two = (MAX_HASHES > 1) && (cfg.hash_count > 2'd1);

	always_comb begin
		if (cfg.bit_count == '0) begin
			nbits = NW'(1);
		end else if (32'(cfg.bit_count) > STORE_BITS) begin
			nbits = NW'(STORE_BITS);
		end else begin
			nbits = NW'(cfg.bit_count);
		end
	end

	always_comb begin
		case (phase_q)
			PH_KEY: begin
				dvd = {1'b0, key_q};
				dvs = p_sel;
			end
			PH_MUL: begin
				dvd = prod_q;
				dvs = p_sel;
			end
			PH_ADD: begin
				dvd = {31'd0, {1'b0, r_q} + {1'b0, b_sel}};
				dvs = p_sel;
			end
			default: begin
				dvd = {32'd0, r_q};
				dvs = 32'(nbits);
			end
		endcase
	end

	bfiq_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dvd), .divisor(dvs), .busy(div_busy), .rem(rem)
	);

	assign sts.div_busy = div_busy;
	assign sts.phase = phase_q;
	assign sts.zero_p = (p_sel == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
		end else if (cmd.load || cmd.start_hash) begin
			phase_q <= PH_KEY;
		end else if (cmd.step_mul) begin
			phase_q <= phase_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= in_command;
			key_q <= in_key;
			fresh_q <= '0;
			all_q <= 1'b1;
		end
		if (cmd.step_mul) begin
			if (sts.zero_p && phase_q != PH_IDX) begin
				r_q <= '0;
			end else begin
				r_q <= rem;
			end
			if (phase_q == PH_KEY) begin
				prod_q <= a_sel * (sts.zero_p ? 32'd0 : rem);
			end
			if (phase_q == PH_IDX) begin
				idx_q <= AW'(rem);
			end
		end
		if (cmd.mem_rd) begin
			rd_q <= mem_q[idx_q];
		end
		if (cmd.take) begin
			if (command_q == CMD_INSERT) begin
				if (!rd_q) begin
					fresh_q <= fresh_q + 2'd1;
				end
			end else if (!rd_q) begin
				all_q <= 1'b0;
			end
		end
		if (cmd.clear_wr) begin
			mem_q[clr_addr] <= 1'b0;
		end else if (cmd.mem_wr && command_q == CMD_INSERT) begin
			mem_q[idx_q] <= 1'b1;
		end
	end

	assign newly_set = (command_q == CMD_INSERT) ? fresh_q : 2'd0;
	assign present = (command_q == CMD_QUERY) ? all_q : 1'b0;
endmodule

### rtl/core/bfiq_ctrl.sv
// ----------------------------------------------------------------------------
// bfiq_ctrl
// Sequencer: clearing pass, per-hash divide phases, bit read/write, result.
// ----------------------------------------------------------------------------
module bfiq_ctrl
	import bfiq_pkg::*;
#(
	parameter int unsigned STORE_BITS = STORE_BITS_DEF
)(
	input logic clk,
	input logic arst_n,
	input dp_sts_t sts,
	input logic used_two,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output dp_cmd_t cmd,
	output logic [$clog2(STORE_BITS)-1:0] clr_addr
);
	localparam int unsigned AW = $clog2(STORE_BITS);
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;
	localparam logic [2:0] ST_TAKE = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;
	logic sel_q;
	logic [AW-1:0] clr_q;
	logic started_q;

	assign clr_addr = clr_q;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		case (state_q)
			ST_CLEAR: cmd.clear_wr = 1'b1;
			ST_IDLE: cmd.load = in_valid;
			ST_START: cmd.div_start = 1'b1;
			ST_WAIT: cmd.step_mul = started_q && !sts.div_busy;
			ST_READ: cmd.mem_rd = 1'b1;
			ST_TAKE: begin
				cmd.take = 1'b1;
				cmd.mem_wr = 1'b1;
				cmd.start_hash = 1'b1;
			end
			default: cmd = cmd;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sel_q <= 1'b0;
			clr_q <= '0;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STORE_BITS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					sel_q <= 1'b0;
					if (in_valid) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					started_q <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (started_q && !sts.div_busy) begin
						started_q <= 1'b0;
						state_q <= (sts.phase == PH_IDX) ? ST_READ : ST_START;
					end
				end
				ST_READ: state_q <= ST_TAKE;
				ST_TAKE: begin
					if (!sel_q && used_two) begin
						sel_q <= 1'b1;
						state_q <= ST_START;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/bloom_filter_insert_query_top.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_top
// Bloom filter with insert and query over a cleared bit store.
// ----------------------------------------------------------------------------
// Input channel carries command (0 insert, 1 query) and a 63-bit key; output
// channel returns one beat per input: newly_set for inserts, present for
// queries. Hash registers are to be written through the APB port only
// while idle, by the user; the block itself does not enforce this. Each
// hash runs four remainders on one shared restoring divider, each with a
// start and a finish step, then a bit read and update.
// One item at a time; the next input is taken once the result beat is
// taken by the receiver. While the output stalls the result holds.
// After reset the block clears the store, one bit per cycle, over all
// STORE_BITS bits before it accepts the first input; configuration
// writes are taken throughout.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_top
	import bfiq_pkg::*;
#(
	parameter int unsigned STORE_BITS = STORE_BITS_DEF,
	parameter int unsigned MAX_HASHES = MAX_HASHES_DEF
)(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_AW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	bfiq_in_if.sink in_ch,
	bfiq_out_if.source out_ch
);
	cfg_t cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic used_two;
	logic [$clog2(STORE_BITS)-1:0] clr_addr;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hash_count <= 2'd1;
			cfg_q.bit_count <= 17'd65536;
			cfg_q.mult_first <= 32'd1;
			cfg_q.offset_first <= 32'd0;
			cfg_q.prime_first <= 32'd2147483647;
			cfg_q.mult_second <= 32'd1;
			cfg_q.offset_second <= 32'd0;
			cfg_q.prime_second <= 32'd2147483629;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				REG_HASH_COUNT: cfg_q.hash_count <= pwdata[1:0];
				REG_BIT_COUNT: cfg_q.bit_count <= pwdata[16:0];
				REG_MULT_FIRST: cfg_q.mult_first <= pwdata;
				REG_OFFSET_FIRST: cfg_q.offset_first <= pwdata;
				REG_PRIME_FIRST: cfg_q.prime_first <= pwdata;
				REG_MULT_SECOND: cfg_q.mult_second <= pwdata;
				REG_OFFSET_SECOND: cfg_q.offset_second <= pwdata;
				REG_PRIME_SECOND: cfg_q.prime_second <= pwdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_HASH_COUNT: prdata = {30'd0, cfg_q.hash_count};
			REG_BIT_COUNT: prdata = {15'd0, cfg_q.bit_count};
			REG_MULT_FIRST: prdata = cfg_q.mult_first;
			REG_OFFSET_FIRST: prdata = cfg_q.offset_first;
			REG_PRIME_FIRST: prdata = cfg_q.prime_first;
			REG_MULT_SECOND: prdata = cfg_q.mult_second;
			REG_OFFSET_SECOND: prdata = cfg_q.offset_second;
			REG_PRIME_SECOND: prdata = cfg_q.prime_second;
			default: prdata = 32'd0;
		endcase
	end

	bfiq_ctrl #(.STORE_BITS(STORE_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .used_two(used_two),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .clr_addr(clr_addr)
	);

	bfiq_datapath #(.STORE_BITS(STORE_BITS), .MAX_HASHES(MAX_HASHES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd), .clr_addr(clr_addr),
		.in_command(in_ch.command), .in_key(in_ch.key), .sts(sts),
		.used_two(used_two), .newly_set(out_ch.newly_set), .present(out_ch.present)
	);
endmodule

### rtl/core/bfiq_checker.sv
// ----------------------------------------------------------------------------
// bfiq_checker
// Port-level checks of the bloom filter block, bound to the top level.
// ----------------------------------------------------------------------------
`include "bloom_filter_insert_query_top_defines.svh"
module bfiq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] newly_set,
	input logic present
);
	`BF_ASSERT_IMPL(a_one_at_a_time, clk, arst_n, out_valid, !in_ready, "input taken with result pending")
	`BF_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && in_ready, !out_valid, "result too early")
	`BF_ASSERT_IMPL(a_fields_exclusive, clk, arst_n, out_valid, (newly_set == 2'd0) || !present, "both fields set")
	`BF_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(newly_set) && $stable(present), "stalled result changed")
endmodule

bind bloom_filter_insert_query_top bfiq_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.newly_set(out_ch.newly_set), .present(out_ch.present)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bloom filter insert/query testbench: APB register setup, directed and
// random insert/query beats, self-checking against an in-bench filter model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
	import bfiq_pkg::*;

	localparam int unsigned NBITS = 65536;
	localparam int unsigned IDLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0] newly_set;
		logic present;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bfiq_in_if in_ch();
	bfiq_out_if out_ch();

	bloom_filter_insert_query_top DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_INSERT;
		in_ch.key = '0;
		out_ch.ready = 1'b0;
	end

	// filter model state
	bit filter_bits [NBITS];
	logic [1:0] m_hashes;
	logic [16:0] m_nbits;
	logic [31:0] m_mult [2];
	logic [31:0] m_off [2];
	logic [31:0] m_prime [2];

	verdict_t pending_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit rx_stall_on = 1'b1;
	bit tx_idle_on = 1'b1;
	int hold_off = 0;

	task automatic model_reset();
		foreach (filter_bits[i]) filter_bits[i] = 1'b0;
		m_hashes = 2'd1;
		m_nbits = 17'd65536;
		m_mult[0] = 32'd1; m_off[0] = 32'd0; m_prime[0] = 32'd2147483647;
		m_mult[1] = 32'd1; m_off[1] = 32'd0; m_prime[1] = 32'd2147483629;
	endtask

	function automatic logic [63:0] hash_value(int w, logic [62:0] key);
		logic [63:0] p, r;
		p = {32'd0, m_prime[w]};
		if (p == 0) return 64'd0;
		r = {1'b0, key} % p;
		r = ({32'd0, m_mult[w]} * r) % p;
		r = (r + {32'd0, m_off[w]}) % p;
		return r;
	endfunction

	function automatic verdict_t filter_step(logic cmd, logic [62:0] key);
		verdict_t v;
		int nh;
		logic [63:0] n, idx;
		logic [1:0] fresh;
		logic all_set;
		nh = (m_hashes == 0) ? 1 : (m_hashes > 2 ? 2 : m_hashes);
		n = (m_nbits == 0) ? 64'd1 : (m_nbits > NBITS ? 64'(NBITS) : 64'(m_nbits));
		fresh = 2'd0;
		all_set = 1'b1;
		for (int i = 0; i < nh; i++) begin
			idx = hash_value(i, key) % n;
			if (cmd == CMD_INSERT) begin
				if (!filter_bits[idx]) begin
					filter_bits[idx] = 1'b1;
					fresh++;
				end
			end else if (!filter_bits[idx]) begin
				all_set = 1'b0;
			end
		end
		v.newly_set = (cmd == CMD_INSERT) ? fresh : 2'd0;
		v.present = (cmd == CMD_INSERT) ? 1'b0 : all_set;
		return v;
	endfunction

	task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (addr)
			REG_HASH_COUNT: m_hashes = data[1:0];
			REG_BIT_COUNT: m_nbits = data[16:0];
			REG_MULT_FIRST: m_mult[0] = data;
			REG_OFFSET_FIRST: m_off[0] = data;
			REG_PRIME_FIRST: m_prime[0] = data;
			REG_MULT_SECOND: m_mult[1] = data;
			REG_OFFSET_SECOND: m_off[1] = data;
			REG_PRIME_SECOND: m_prime[1] = data;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic send_beat(logic cmd, logic [62:0] key);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.key <= key;
		do @(posedge clk); while (!in_ch.ready);
		pending_q.push_back(filter_step(cmd, key));
	endtask

	task automatic end_stream();
		in_ch.valid <= 1'b0;
	endtask

	function automatic logic [62:0] rand_key();
		logic [62:0] k;
		k = 63'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: k = k & 63'hFF;
			1: k = k & 63'hFFFF_FFFF;
			default: ;
		endcase
		return k;
	endfunction

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				idle_cycles <= 0;
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected beat ns=%0d p=%0d",
						out_ch.newly_set, out_ch.present);
				end else begin
					verdict_t e;
					e = pending_q.pop_front();
					if (e.newly_set !== out_ch.newly_set || e.present !== out_ch.present) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp ns=%0d p=%0d got ns=%0d p=%0d",
								e.newly_set, e.present, out_ch.newly_set, out_ch.present);
					end
				end
			end else if (in_ch.valid && in_ch.ready) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (hold_off > 0) begin
				out_ch.ready <= 1'b0;
				hold_off <= hold_off - 1;
			end else if (rx_stall_on) begin
				out_ch.ready <= ($urandom_range(0, 3) != 0);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		send_beat(CMD_QUERY, 63'd0);
		send_beat(CMD_INSERT, 63'd0);
		send_beat(CMD_QUERY, 63'd0);
		send_beat(CMD_INSERT, 63'h7FFF_FFFF_FFFF_FFFF);
		send_beat(CMD_QUERY, 63'h7FFF_FFFF_FFFF_FFFF);
		send_beat(CMD_INSERT, 63'h7FFF_FFFF_FFFF_FFFF);
		send_beat(CMD_QUERY, 63'h5555_5555_5555_5555);
		end_stream();
		drain();
	endtask

	task automatic test_edge_config();
		write_reg(REG_HASH_COUNT, 32'hFFFF_FFFF);
		write_reg(REG_BIT_COUNT, 32'd0);
		send_beat(CMD_INSERT, 63'd12345);
		send_beat(CMD_QUERY, 63'd999);
		end_stream();
		drain();
		write_reg(REG_HASH_COUNT, 32'd0);
		write_reg(REG_BIT_COUNT, 32'h1FFFF);
		write_reg(REG_PRIME_FIRST, 32'd0);
		send_beat(CMD_INSERT, 63'd77);
		send_beat(CMD_QUERY, 63'd78);
		end_stream();
		drain();
		write_reg(REG_HASH_COUNT, 32'd2);
		write_reg(REG_BIT_COUNT, 32'd1);
		write_reg(REG_PRIME_FIRST, 32'hFFFF_FFFF);
		write_reg(REG_MULT_FIRST, 32'hFFFF_FFFF);
		write_reg(REG_OFFSET_FIRST, 32'hFFFF_FFFF);
		write_reg(REG_PRIME_SECOND, 32'd2);
		write_reg(REG_MULT_SECOND, 32'd0);
		write_reg(REG_OFFSET_SECOND, 32'hFFFF_FFFF);
		send_beat(CMD_QUERY, 63'd5);
		send_beat(CMD_INSERT, 63'h7FFF_FFFF_FFFF_FFFF);
		end_stream();
		drain();
		write_reg(REG_BIT_COUNT, 32'd100);
		write_reg(REG_PRIME_FIRST, 32'd100);
		write_reg(REG_OFFSET_FIRST, 32'd0);
		write_reg(REG_MULT_FIRST, 32'd1);
		write_reg(REG_PRIME_SECOND, 32'd100);
		write_reg(REG_MULT_SECOND, 32'd1);
		write_reg(REG_OFFSET_SECOND, 32'd0);
		send_beat(CMD_INSERT, 63'd40); // both hashes pick one bit
		send_beat(CMD_QUERY, 63'd40);
		send_beat(CMD_QUERY, 63'd41);
		end_stream();
		drain();
	endtask

	task automatic random_phase(int count, bit long_hold, bit tx_pause);
		for (int i = 0; i < count; i++) begin
			if (long_hold && i == 2) hold_off = 3000;
			if (tx_pause && i == count / 2) begin
				end_stream();
				while (pending_q.size() != 0) @(posedge clk);
			end
			send_beat($urandom_range(0, 2) == 0 ? CMD_INSERT : CMD_QUERY, rand_key());
			if ($urandom_range(0, 1)) send_beat(CMD_QUERY, rand_key());
		end
		end_stream();
		drain();
	endtask

	task automatic test_random_configs();
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_HASH_COUNT, $urandom_range(0, 3));
			write_reg(REG_BIT_COUNT, ph == 7 ? 32'd65536 : $urandom_range(1, 2048));
			write_reg(REG_MULT_FIRST, $urandom);
			write_reg(REG_OFFSET_FIRST, $urandom);
			write_reg(REG_PRIME_FIRST, ph == 3 ? 32'd0 : $urandom_range(2, 32'hFFFF_FFFF));
			write_reg(REG_MULT_SECOND, $urandom);
			write_reg(REG_OFFSET_SECOND, $urandom);
			write_reg(REG_PRIME_SECOND, ph == 5 ? 32'd1 : $urandom);
			if (ph == 6) begin
				tx_idle_on = 1'b0;
				rx_stall_on = 1'b0;
			end
			random_phase(110, ph == 1, ph == 2);
		end
	endtask

	initial begin
		model_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_edge_config();
		test_random_configs();
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

### files.f
+incdir+rtl/core
rtl/core/bfiq_pkg.sv
rtl/core/bfiq_if.sv
rtl/core/bfiq_div.sv
rtl/core/bfiq_datapath.sv
rtl/core/bfiq_ctrl.sv
rtl/core/bloom_filter_insert_query_top.sv
rtl/core/bfiq_checker.sv
tb/tb_top.sv
